[sv/sse_pkg.sv]
package sse_pkg;

  // Default build parameters
  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  // Register fields
  localparam int unsigned IMG_WIDTH_W  = 11;
  localparam int unsigned IMG_HEIGHT_W = 12;
  localparam int unsigned OCTAVE_W     = 3;
  localparam int unsigned SCALE_W      = 4;

  // Result fields
  localparam int unsigned KEY_ROW_W   = 12;
  localparam int unsigned KEY_COL_W   = 10;
  localparam int unsigned KEY_PACK_W  = KEY_ROW_W + KEY_COL_W + OCTAVE_W + SCALE_W;
  localparam int unsigned OUT_TDATA_W = ((KEY_PACK_W + 7) / 8) * 8;

  // Register reset values
  localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = IMG_WIDTH_W'(1024);
  localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = IMG_HEIGHT_W'(1024);
  localparam logic [OCTAVE_W-1:0]     OCTAVE_RST     = '0;
  localparam logic [SCALE_W-1:0]      SCALE_RST      = SCALE_W'(1);

  // Smallest frame dimension the window logic supports
  localparam int unsigned MIN_DIM = 3;

  // Number of window columns, rows and layers
  localparam int unsigned NUM_COLS   = 3;
  localparam int unsigned NUM_ROWS   = 3;
  localparam int unsigned NUM_LAYERS = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMG_WIDTH  = 2'd0,
    REG_IMG_HEIGHT = 2'd1,
    REG_OCTAVE     = 2'd2,
    REG_SCALE      = 2'd3
  } cfg_reg_e;

  // Per-lane compare outcome
  typedef struct packed {
    logic ge_all;
    logic le_all;
  } lane_flags_t;

  // Merged outcome
  typedef struct packed {
    logic hit;
    logic is_max;
  } det_t;

endpackage

[sv/sse_linebuf.sv]
module sse_linebuf #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 48
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_prev_i,
  input  logic [DW-1:0] wr_back_i,
  output logic [DW-1:0] rd_prev_o,
  output logic [DW-1:0] rd_back_o
);

  logic [DW-1:0] prev_mem [DEPTH];
  logic [DW-1:0] back_mem [DEPTH];
  logic [DW-1:0] rd_prev_q;
  logic [DW-1:0] rd_back_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      prev_mem[wr_addr_i] <= wr_prev_i;
      back_mem[wr_addr_i] <= wr_back_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_prev_q <= prev_mem[rd_addr_i];
      rd_back_q <= back_mem[rd_addr_i];
    end
  end

  assign rd_prev_o = rd_prev_q;
  assign rd_back_o = rd_back_q;

endmodule

[sv/sse_lane.sv]
module sse_lane #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic signed [SAMPLE_BITS-1:0] center_i,
  input  logic signed [SAMPLE_BITS-1:0] col_i [sse_pkg::NUM_ROWS][sse_pkg::NUM_LAYERS],
  output sse_pkg::lane_flags_t          flags_o
);

  // The center compared against itself passes both tests, so no skip is needed.
  always_comb begin
    flags_o.ge_all = 1'b1;
    flags_o.le_all = 1'b1;
    for (int r = 0; r < sse_pkg::NUM_ROWS; r++) begin
      for (int l = 0; l < sse_pkg::NUM_LAYERS; l++) begin
        if (center_i < col_i[r][l]) flags_o.ge_all = 1'b0;
        if (center_i > col_i[r][l]) flags_o.le_all = 1'b0;
      end
    end
  end

endmodule

[sv/sse_merge.sv]
module sse_merge (
  input  logic                 valid_i,
  input  sse_pkg::lane_flags_t lanes_i [sse_pkg::NUM_COLS],
  output sse_pkg::det_t        det_o
);

  logic is_max;
  logic is_min;

  always_comb begin
    is_max = 1'b1;
    is_min = 1'b1;
    for (int i = 0; i < sse_pkg::NUM_COLS; i++) begin
      is_max = is_max & lanes_i[i].ge_all;
      is_min = is_min & lanes_i[i].le_all;
    end
  end

  // Maximum wins a full tie
  assign det_o.hit    = valid_i & (is_max | is_min);
  assign det_o.is_max = is_max;

endmodule

[sv/scale_space_extremum_detect.sv]
// Path: a pixel passes stage B (line-store read with lane compare), then stage C
// (merge into the output register). Throughput: one pixel per cycle unless the
// output stalls, set by the single read and write port of each line store.
// Reset: counters, window, valid flags and configuration registers return to defaults at once;
// line stores are not cleared and read as undefined until written.
module scale_space_extremum_detect #(
  parameter int unsigned MAX_WIDTH   = sse_pkg::MAX_WIDTH_DEF,
  parameter int unsigned SAMPLE_BITS = sse_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                                 cfg_we_i,
  input  logic [sse_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [sse_pkg::CFG_DATA_W-1:0]       cfg_data_i,

  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // dog_below, dog_center, dog_above, zero padding
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // frame_start
  input  logic                                 s_axis_tuser,

  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // key_row, key_col, key_octave, key_scale, zero padding
  output logic [sse_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // is_maximum
  output logic                                 m_axis_tuser
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = (CW + 1 > sse_pkg::IMG_WIDTH_W) ? CW + 1 : sse_pkg::IMG_WIDTH_W;
  localparam int unsigned RW  = sse_pkg::IMG_HEIGHT_W;
  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned MDW = sse_pkg::NUM_LAYERS * SAMPLE_BITS;
  localparam int unsigned PAD = sse_pkg::OUT_TDATA_W - sse_pkg::KEY_PACK_W;

  typedef logic signed [SB-1:0] smp_t;

  // Configuration registers
  logic [sse_pkg::IMG_WIDTH_W-1:0]  img_width_q;
  logic [sse_pkg::IMG_HEIGHT_W-1:0] img_height_q;
  logic [sse_pkg::OCTAVE_W-1:0]     octave_q;
  logic [sse_pkg::SCALE_W-1:0]      scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= sse_pkg::IMG_WIDTH_RST;
      img_height_q <= sse_pkg::IMG_HEIGHT_RST;
      octave_q     <= sse_pkg::OCTAVE_RST;
      scale_q      <= sse_pkg::SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (sse_pkg::cfg_reg_e'(cfg_idx_i))
        sse_pkg::REG_IMG_WIDTH:  img_width_q  <= cfg_data_i[sse_pkg::IMG_WIDTH_W-1:0];
        sse_pkg::REG_IMG_HEIGHT: img_height_q <= cfg_data_i[sse_pkg::IMG_HEIGHT_W-1:0];
        sse_pkg::REG_OCTAVE:     octave_q     <= cfg_data_i[sse_pkg::OCTAVE_W-1:0];
        sse_pkg::REG_SCALE:      scale_q      <= cfg_data_i[sse_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake chain
  logic accept;
  logic ready_b;
  logic ready_c;
  logic o_ready;
  logic b_fire;

  logic b_valid_q;
  logic c_valid_q;
  logic o_valid_q;

  assign o_ready       = !o_valid_q || m_axis_tready;
  assign ready_c       = !c_valid_q || o_ready;
  assign ready_b       = !b_valid_q || ready_c;
  assign s_axis_tready = ready_b;
  assign accept        = s_axis_tvalid && ready_b;
  assign b_fire        = b_valid_q && ready_c;

  // Position counters
  logic [CW-1:0] col_q, col_d, col_cur;
  logic [RW-1:0] row_q, row_d, row_cur;
  logic [WW-1:0] w_raw, w_eff, col_inc;
  logic [RW-1:0] h_eff;
  logic [RW:0]   row_inc;

  always_comb begin
    w_raw = WW'(img_width_q);
    if (w_raw < WW'(sse_pkg::MIN_DIM)) begin
      w_eff = WW'(sse_pkg::MIN_DIM);
    end else if (w_raw > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_eff   = (img_height_q < RW'(sse_pkg::MIN_DIM)) ? RW'(sse_pkg::MIN_DIM) : img_height_q;
    col_cur = s_axis_tuser ? '0 : col_q;
    row_cur = s_axis_tuser ? '0 : row_q;
    col_inc = WW'(col_cur) + WW'(1);
    row_inc = {1'b0, row_cur} + (RW+1)'(1);
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[RW-1:0];
    end else begin
      col_d = col_inc[CW-1:0];
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage B: line-store data arrives, lanes compare
  logic [CW-1:0] b_col_q;
  logic [RW-1:0] b_row_q;
  logic          b_interior_q;
  logic          b_fwd_q;
  smp_t          b_in_q   [sse_pkg::NUM_LAYERS];
  smp_t          b_fwd0_q [sse_pkg::NUM_LAYERS];
  smp_t          b_fwd1_q [sse_pkg::NUM_LAYERS];
  logic          fwd_d;

  logic [MDW-1:0] rd_prev, rd_back, wr_prev, wr_back;

  smp_t cur  [sse_pkg::NUM_ROWS][sse_pkg::NUM_LAYERS];
  smp_t win0_q [sse_pkg::NUM_ROWS][sse_pkg::NUM_LAYERS];
  smp_t win1_q [sse_pkg::NUM_ROWS][sse_pkg::NUM_LAYERS];

  // The pixel in stage B writes its column this cycle; a read of the same
  // column by the incoming pixel takes the write data instead.
  assign fwd_d = b_fire && (b_col_q == col_cur);

  always_comb begin
    for (int l = 0; l < sse_pkg::NUM_LAYERS; l++) begin
      cur[0][l] = b_fwd_q ? b_fwd0_q[l] : smp_t'(rd_back[l*SB +: SB]);
      cur[1][l] = b_fwd_q ? b_fwd1_q[l] : smp_t'(rd_prev[l*SB +: SB]);
      cur[2][l] = b_in_q[l];
      wr_back[l*SB +: SB] = cur[1][l];
      wr_prev[l*SB +: SB] = cur[2][l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_col_q      <= col_cur;
      b_row_q      <= row_cur;
      b_interior_q <= (row_cur >= RW'(2)) && (col_cur >= CW'(2));
      b_fwd_q      <= fwd_d;
      for (int l = 0; l < sse_pkg::NUM_LAYERS; l++) begin
        b_in_q[l]   <= smp_t'(s_axis_tdata[l*SB +: SB]);
        b_fwd0_q[l] <= cur[1][l];
        b_fwd1_q[l] <= cur[2][l];
      end
    end
  end

  sse_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (MDW)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_cur),
    .wr_en_i   (b_fire),
    .wr_addr_i (b_col_q),
    .wr_prev_i (wr_prev),
    .wr_back_i (wr_back),
    .rd_prev_o (rd_prev),
    .rd_back_o (rd_back)
  );

  // Column window: win0 one column back, win1 two back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < sse_pkg::NUM_ROWS; r++) begin
        for (int l = 0; l < sse_pkg::NUM_LAYERS; l++) begin
          win0_q[r][l] <= '0;
          win1_q[r][l] <= '0;
        end
      end
    end else if (b_fire) begin
      win1_q <= win0_q;
      win0_q <= cur;
    end
  end

  sse_pkg::lane_flags_t lane_flags [sse_pkg::NUM_COLS];

  sse_lane #(.SAMPLE_BITS(SB)) u_lane_old (
    .center_i (win0_q[1][1]),
    .col_i    (win1_q),
    .flags_o  (lane_flags[0])
  );

  sse_lane #(.SAMPLE_BITS(SB)) u_lane_mid (
    .center_i (win0_q[1][1]),
    .col_i    (win0_q),
    .flags_o  (lane_flags[1])
  );

  sse_lane #(.SAMPLE_BITS(SB)) u_lane_new (
    .center_i (win0_q[1][1]),
    .col_i    (cur),
    .flags_o  (lane_flags[2])
  );

  // Stage C: merge lane results
  sse_pkg::lane_flags_t c_flags_q [sse_pkg::NUM_COLS];
  logic [CW-1:0]        c_col_q;
  logic [RW-1:0]        c_row_q;
  sse_pkg::det_t        det;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (ready_c) c_valid_q <= b_valid_q && b_interior_q;
      if (ready_b) b_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      c_flags_q <= lane_flags;
      c_col_q   <= b_col_q - CW'(1);
      c_row_q   <= b_row_q - RW'(1);
    end
  end

  sse_merge u_merge (
    .valid_i (c_valid_q),
    .lanes_i (c_flags_q),
    .det_o   (det)
  );

  // Output register
  logic [sse_pkg::KEY_ROW_W-1:0] o_row_q;
  logic [sse_pkg::KEY_COL_W-1:0] o_col_q;
  logic [sse_pkg::OCTAVE_W-1:0]  o_octave_q;
  logic [sse_pkg::SCALE_W-1:0]   o_scale_q;
  logic                          o_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_ready) begin
      o_valid_q <= det.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && det.hit) begin
      o_row_q    <= sse_pkg::KEY_ROW_W'(c_row_q);
      o_col_q    <= sse_pkg::KEY_COL_W'(c_col_q);
      o_octave_q <= octave_q;
      o_scale_q  <= scale_q;
      o_max_q    <= det.is_max;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {{PAD{1'b0}}, o_scale_q, o_octave_q, o_col_q, o_row_q};
  assign m_axis_tuser  = o_max_q;

`ifndef SYNTHESIS
  a_frame_start_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser |=> b_valid_q && b_col_q == '0 && b_row_q == '0)
    else $error("frame start did not restart the position counters");

  a_key_not_border_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q |-> o_row_q != '0)
    else $error("keypoint reported on the top border row");

  a_merge_not_border_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> c_col_q != '0)
    else $error("border column reached the merge stage");
`endif

endmodule

[verif/scale_space_extremum_detect_test.sv]
`timescale 1ns / 1ps

module scale_space_extremum_detect_test;

  localparam int unsigned SB   = sse_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned MAXW = sse_pkg::MAX_WIDTH_DEF;
  localparam int unsigned CDW  = sse_pkg::CFG_DATA_W;
  localparam int unsigned KRW  = sse_pkg::KEY_ROW_W;
  localparam int unsigned KCW  = sse_pkg::KEY_COL_W;
  localparam int unsigned OCW  = sse_pkg::OCTAVE_W;
  localparam int unsigned SCW  = sse_pkg::SCALE_W;
  localparam int unsigned OTW  = sse_pkg::OUT_TDATA_W;
  localparam int unsigned KPW  = sse_pkg::KEY_PACK_W;

  localparam int unsigned DOG_TDATA_W = ((3 * SB + 7) / 8) * 8;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned RANDOM_PIXELS = 300;

  typedef logic signed [SB-1:0] sample_t;

  typedef struct packed {
    logic          frame_start;
    logic [SB-1:0] above;
    logic [SB-1:0] center;
    logic [SB-1:0] below;
  } pixel_t;

  typedef struct packed {
    logic [KRW-1:0] row;
    logic [KCW-1:0] col;
    logic [OCW-1:0] octave;
    logic [SCW-1:0] scale;
    logic           is_max;
  } keypoint_t;

  typedef enum {FILL_RANDOM, FILL_NARROW, FILL_FLAT, FILL_PLANTED, FILL_NOISE} fill_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          cfg_we_i = 1'b0;
  logic [sse_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CDW-1:0]                cfg_data_i = '0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // dog_below, dog_center, dog_above
  logic [DOG_TDATA_W-1:0] s_axis_tdata = '0;
  // frame_start
  logic                   s_axis_tuser = 1'b0;

  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // key_row, key_col, key_octave, key_scale, zero padding
  logic [OTW-1:0]         m_axis_tdata;
  // is_maximum
  logic                   m_axis_tuser;

  // Predictor state: line stores, two-column window, raster position, registers
  sample_t line_prev [MAXW][3];
  sample_t line_two_back [MAXW][3];
  sample_t window_col [2][3][3];
  int unsigned row_pos;
  int unsigned col_pos;
  logic [sse_pkg::IMG_WIDTH_W-1:0]  width_reg = sse_pkg::IMG_WIDTH_RST;
  logic [sse_pkg::IMG_HEIGHT_W-1:0] height_reg = sse_pkg::IMG_HEIGHT_RST;
  logic [OCW-1:0]                   octave_reg = sse_pkg::OCTAVE_RST;
  logic [SCW-1:0]                   scale_reg = sse_pkg::SCALE_RST;

  pixel_t    pending_pixels [$];
  keypoint_t expected_keypoints [$];
  pixel_t    offered_pixel;
  keypoint_t seen_kp;
  keypoint_t want_kp;

  bit          idle_on = 1'b0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned sink_hold = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned random_items = 0;

  scale_space_extremum_detect uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned eff_width(input logic [sse_pkg::IMG_WIDTH_W-1:0] value);
    if (value < sse_pkg::MIN_DIM) return sse_pkg::MIN_DIM;
    if (value > MAXW) return MAXW;
    return int'(value);
  endfunction

  function automatic int unsigned eff_height(input logic [sse_pkg::IMG_HEIGHT_W-1:0] value);
    return (value < sse_pkg::MIN_DIM) ? sse_pkg::MIN_DIM : int'(value);
  endfunction

  // Advance the raster window by one pixel and queue a keypoint if the
  // center of the 3x3x3 neighborhood is an extremum.
  task automatic detect_extremum(input pixel_t px);
    int unsigned w, h, c, r, i, j, l;
    sample_t cur [3][3];
    sample_t nb [3][3][3];
    sample_t mid;
    logic ge_all, le_all;
    keypoint_t kp;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    if (px.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    c = (col_pos >= MAXW) ? MAXW - 1 : col_pos;
    r = row_pos;
    cur[2][0] = px.below;
    cur[2][1] = px.center;
    cur[2][2] = px.above;
    for (l = 0; l < 3; l++) begin
      cur[0][l] = line_two_back[c][l];
      cur[1][l] = line_prev[c][l];
    end
    for (i = 0; i < 3; i++) begin
      for (l = 0; l < 3; l++) begin
        nb[0][i][l] = window_col[1][i][l];
        nb[1][i][l] = window_col[0][i][l];
        nb[2][i][l] = cur[i][l];
      end
    end
    if (r >= 2 && c >= 2) begin
      mid = nb[1][1][1];
      ge_all = 1'b1;
      le_all = 1'b1;
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          for (l = 0; l < 3; l++) begin
            if (!(i == 1 && j == 1 && l == 1)) begin
              if (mid < nb[i][j][l]) ge_all = 1'b0;
              if (mid > nb[i][j][l]) le_all = 1'b0;
            end
          end
        end
      end
      // ties satisfy both tests; maximum takes precedence
      if (ge_all || le_all) begin
        kp.row = KRW'(r - 1);
        kp.col = KCW'(c - 1);
        kp.octave = octave_reg;
        kp.scale = scale_reg;
        kp.is_max = ge_all;
        expected_keypoints = {expected_keypoints, kp};
      end
    end
    for (l = 0; l < 3; l++) begin
      line_two_back[c][l] = cur[1][l];
      line_prev[c][l] = cur[2][l];
    end
    for (i = 0; i < 3; i++) begin
      for (l = 0; l < 3; l++) begin
        window_col[1][i][l] = window_col[0][i][l];
        window_col[0][i][l] = cur[i][l];
      end
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic write_reg(input sse_pkg::cfg_reg_e idx, input logic [CDW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      sse_pkg::REG_IMG_WIDTH: width_reg = value[sse_pkg::IMG_WIDTH_W-1:0];
      sse_pkg::REG_IMG_HEIGHT: height_reg = value[sse_pkg::IMG_HEIGHT_W-1:0];
      sse_pkg::REG_OCTAVE: octave_reg = value[OCW-1:0];
      default: scale_reg = value[SCW-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until the sender is empty and every keypoint has arrived, then let
  // the pipeline settle in case the last pixels produce nothing.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || s_axis_tvalid || expected_keypoints.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_pixels(input int unsigned w, input int unsigned h, input int unsigned count,
                              input fill_e fill, input bit with_start, input bit split);
    pixel_t px;
    logic [SB-1:0] level;
    int unsigned i, r, c;
    level = SB'($urandom());
    @(negedge clk_i);
    for (i = 0; i < count; i++) begin
      // pause the sender mid-frame until all keypoints so far are out
      if (split && i == count / 2) wait_drained();
      r = (i / w) % h;
      c = i % w;
      case (fill)
        FILL_NARROW: begin
          px.below = SB'($urandom_range(0, 2)) - 1'b1;
          px.center = SB'($urandom_range(0, 2)) - 1'b1;
          px.above = SB'($urandom_range(0, 2)) - 1'b1;
        end
        FILL_FLAT: begin
          px.below = level;
          px.center = level;
          px.above = level;
        end
        default: begin
          px.below = SB'($urandom());
          px.center = SB'($urandom());
          px.above = SB'($urandom());
        end
      endcase
      px.frame_start = (i == 0 && with_start) || (fill == FILL_NOISE && $urandom_range(0, 31) == 0);
      // plant peaks and pits, always at the first and last interior pixel
      if (fill == FILL_PLANTED &&
          ((r == 1 && c == 1) || (r == h - 2 && c == w - 2) || $urandom_range(0, 7) == 0))
        px.center = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      pending_pixels = {pending_pixels, px};
    end
  endtask

  task automatic run_random_phase(input bit idle);
    int unsigned prev_w, w_eff, h_eff, frames, n, k;
    logic [CDW-1:0] w_val, h_val;
    bit start;
    wait_drained();
    prev_w = eff_width(width_reg);
    case ($urandom_range(0, 9))
      0: w_val = CDW'($urandom_range(0, 2));
      1: w_val = CDW'($urandom_range(13, 24));
      2: w_val = CDW'(12'h800 | $urandom_range(0, 12));
      default: w_val = CDW'($urandom_range(3, 12));
    endcase
    case ($urandom_range(0, 6))
      0: h_val = CDW'($urandom_range(0, 2));
      1: h_val = CDW'($urandom_range(9, 12));
      default: h_val = CDW'($urandom_range(3, 8));
    endcase
    if ($urandom_range(0, 3) != 0) write_reg(sse_pkg::REG_IMG_WIDTH, w_val);
    if ($urandom_range(0, 3) != 0) write_reg(sse_pkg::REG_IMG_HEIGHT, h_val);
    if ($urandom_range(0, 3) != 0) write_reg(sse_pkg::REG_OCTAVE, CDW'($urandom_range(0, 7)));
    if ($urandom_range(0, 3) != 0) write_reg(sse_pkg::REG_SCALE, CDW'($urandom_range(0, 15)));
    w_eff = eff_width(width_reg);
    h_eff = eff_height(height_reg);
    // a wider row needs a fresh frame so no unwritten store entry is ever used
    start = (w_eff > prev_w) || ($urandom_range(0, 1) == 0);
    @(negedge clk_i);
    idle_on = idle;
    frames = $urandom_range(1, 2);
    for (k = 0; k < frames; k++) begin
      queue_pixels(w_eff, h_eff, w_eff * h_eff, fill_e'($urandom_range(0, 4)), start || k > 0,
                   $urandom_range(0, 5) == 0);
      random_items += w_eff * h_eff;
    end
    // leave the raster position mid-frame for the next phase
    n = $urandom_range(0, 2 * w_eff);
    queue_pixels(w_eff, h_eff, n, FILL_RANDOM, 1'b0, 1'b0);
    random_items += n;
  endtask

  // Pixel source
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) detect_extremum(offered_pixel);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          offered_pixel = pending_pixels.pop_front();
          s_axis_tdata <= DOG_TDATA_W'({offered_pixel.above, offered_pixel.center,
                                        offered_pixel.below});
          s_axis_tuser <= offered_pixel.frame_start;
          s_axis_tvalid <= 1'b1;
          if (idle_on && $urandom_range(0, 11) == 0) src_gap = $urandom_range(1, 15);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Keypoint sink and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_kp.row = m_axis_tdata[KRW-1:0];
        seen_kp.col = m_axis_tdata[KRW +: KCW];
        seen_kp.octave = m_axis_tdata[KRW + KCW +: OCW];
        seen_kp.scale = m_axis_tdata[KRW + KCW + OCW +: SCW];
        seen_kp.is_max = m_axis_tuser;
        if (expected_keypoints.size() == 0) begin
          mismatches++;
          $display({"%0t: unexpected keypoint: expected none, actual row %0d col %0d ",
                    "oct %0d scale %0d max %0b"},
                   $time, seen_kp.row, seen_kp.col, seen_kp.octave, seen_kp.scale,
                   seen_kp.is_max);
        end else begin
          want_kp = expected_keypoints.pop_front();
          if (seen_kp.row !== want_kp.row || seen_kp.col !== want_kp.col ||
              seen_kp.octave !== want_kp.octave || seen_kp.scale !== want_kp.scale ||
              seen_kp.is_max !== want_kp.is_max ||
              m_axis_tdata[OTW-1:KPW] !== '0) begin
            mismatches++;
            $display({"%0t: keypoint mismatch: expected row %0d col %0d oct %0d scale %0d ",
                      "max %0b, actual row %0d col %0d oct %0d scale %0d max %0b pad %h"},
                     $time, want_kp.row, want_kp.col, want_kp.octave, want_kp.scale,
                     want_kp.is_max, seen_kp.row, seen_kp.col, seen_kp.octave, seen_kp.scale,
                     seen_kp.is_max, m_axis_tdata[OTW-1:KPW]);
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 15) == 0) sink_gap = $urandom_range(1, 15);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("** scale_space_extremum_detect: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    pixel_t px;
    int unsigned i, j, l;
    for (i = 0; i < 2; i++)
      for (j = 0; j < 3; j++)
        for (l = 0; l < 3; l++)
          window_col[i][j][l] = '0;
    for (i = 0; i < MAXW; i++)
      for (l = 0; l < 3; l++) begin
        line_prev[i][l] = '0;
        line_two_back[i][l] = '0;
      end
    row_pos = 0;
    col_pos = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Smallest frames: lone peak at full scale, lone pit, then a flat frame
    // under out-of-range dimensions
    write_reg(sse_pkg::REG_IMG_WIDTH, CDW'(3));
    write_reg(sse_pkg::REG_IMG_HEIGHT, CDW'(3));
    write_reg(sse_pkg::REG_OCTAVE, CDW'(7));
    write_reg(sse_pkg::REG_SCALE, CDW'(15));
    @(negedge clk_i);
    idle_on = 1'b1;
    for (i = 0; i < 18; i++) begin
      px.frame_start = (i % 9 == 0);
      if (i < 9) begin
        px.below = 16'h8000;
        px.center = (i == 4) ? 16'h7FFF : 16'h8000;
        px.above = 16'h8000;
      end else begin
        px.below = 16'h7FFF;
        px.center = (i == 13) ? 16'h8000 : 16'h7FFF;
        px.above = 16'h7FFF;
      end
      pending_pixels = {pending_pixels, px};
    end
    wait_drained();
    write_reg(sse_pkg::REG_IMG_WIDTH, CDW'(0));
    write_reg(sse_pkg::REG_IMG_HEIGHT, CDW'(2));
    write_reg(sse_pkg::REG_OCTAVE, CDW'(0));
    write_reg(sse_pkg::REG_SCALE, CDW'(0));
    queue_pixels(3, 3, 9, FILL_FLAT, 1'b1, 1'b0);

    while (random_items < RANDOM_PIXELS) run_random_phase($urandom_range(0, 3) != 0);

    // Hold the sink off while a flat frame floods the output
    wait_drained();
    write_reg(sse_pkg::REG_IMG_WIDTH, CDW'(10));
    write_reg(sse_pkg::REG_IMG_HEIGHT, CDW'(10));
    @(negedge clk_i);
    sink_hold = 300;
    queue_pixels(10, 10, 100, FILL_FLAT, 1'b1, 1'b0);

    for (i = 0; i < 3; i++) run_random_phase(1'b0);
    wait_drained();

    if (mismatches == 0 && expected_keypoints.size() == 0) begin
      $display("** scale_space_extremum_detect: PASSED **");
    end else begin
      $display("** scale_space_extremum_detect: FAILED **");
    end
    $finish;
  end

endmodule
